@@ rtl/core/bba_pkg.sv @@
`default_nettype none
package bba_pkg;

    localparam logic [2:0] CMD_SET   = 3'd0;
    localparam logic [2:0] CMD_CLEAR = 3'd1;
    localparam logic [2:0] CMD_TEST  = 3'd2;
    localparam logic [2:0] CMD_FFS   = 3'd3;
    localparam logic [2:0] CMD_ALLOC = 3'd4;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOSPACE = 2'd1;
    localparam logic [1:0] ST_RANGE   = 2'd2;

    localparam int          SIZE_W     = 9;
    localparam int          POS_W      = 10;
    localparam logic [8:0]  SIZE_RESET = 9'd256;

    typedef struct packed {
        logic [2:0] cmd;
        logic [7:0] bit_index;
    } in_item_t;

    typedef struct packed {
        logic [1:0] status;
        logic       bit_value;
        logic [8:0] position;
    } out_item_t;

    typedef struct packed {
        logic             hit;
        logic [POS_W-1:0] pos;
        logic             in_size;
    } eval_t;

endpackage
`default_nettype wire

@@ rtl/core/bitmap_bit_allocator_unit.sv @@
`default_nettype none
// Bitmap bit allocator: set, clear/free, test, find-first-set and allocate
// on a bitmap of MAX_BITS bits held one byte per memory word.
// Input channel s_valid/s_ready/s_data carries one command per transfer;
// output channel m_valid/m_ready/m_data returns exactly one result each.
// cfg_valid/cfg_ready/cfg_data writes size_in_use (always ready); write it
// only while no command is in flight.
// One command at a time: s_ready is high only when the sequencer is idle.
// Set, clear and test read their one byte; the result is registered as soon as
// the output register is free. Find-first-set and allocate read one byte per
// cycle through the shared byte evaluator, from byte 0 until a hit or the end
// of the size.
// The result sits in an output register; a stalled receiver holds it and
// the next command may be accepted meanwhile, finishing once the register
// frees up.
// Reset clears the bitmap (per-byte valid flags), sets size_in_use to 256
// and drops m_valid.
module bitmap_bit_allocator_unit import bba_pkg::*; #(
    parameter int MAX_BITS = 256
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire in_item_t          s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output out_item_t              m_data,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [SIZE_W-1:0] cfg_data
);

    localparam int MAP_BYTES = (MAX_BITS + 7) / 8;
    localparam int DEPTH     = (MAP_BYTES < 64) ? MAP_BYTES : 64;
    localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [POS_W-1:0] CAP = (MAX_BITS > 511) ? 10'd511 : 10'(MAX_BITS);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_OP   = 1'b1;

    logic              state_reg, state_next;
    logic [2:0]        cmd_reg, cmd_next;
    logic [7:0]        bit_reg, bit_next;
    logic [POS_W-1:0]  base_reg, base_next;
    logic [SIZE_W-1:0] size_reg;
    logic              m_valid_reg, m_valid_next;
    out_item_t         out_reg, out_next;

    logic [POS_W-1:0]  eff_size;
    logic [POS_W-1:0]  bit_w;
    logic [7:0]        rd_byte;
    logic              wr_en;
    logic [7:0]        wr_data;
    logic [7:0]        bit_mask;
    logic              out_free;
    eval_t             ev;

    assign eff_size  = ({1'b0, size_reg} > CAP) ? CAP : {1'b0, size_reg};
    assign bit_w     = {2'b00, bit_reg};
    assign bit_mask  = 8'h01 << bit_reg[2:0];
    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = out_reg;

    bba_map_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_addr (base_next[AW+2:3]),
        .rd_data (rd_byte),
        .wr_en   (wr_en),
        .wr_addr (base_reg[AW+2:3]),
        .wr_data (wr_data)
    );

    bba_byte_eval u_eval (
        .byte_in   (rd_byte),
        .find_zero (cmd_reg == CMD_ALLOC),
        .base      (base_reg),
        .eff_size  (eff_size),
        .res       (ev)
    );

    always_comb begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        bit_next     = bit_reg;
        base_next    = base_reg;
        out_next     = out_reg;
        m_valid_next = m_valid_reg && !m_ready;
        wr_en        = 1'b0;
        wr_data      = rd_byte;

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd_next   = s_data.cmd;
                    bit_next   = s_data.bit_index;
                    state_next = S_OP;
                    if (s_data.cmd == CMD_SET || s_data.cmd == CMD_CLEAR ||
                        s_data.cmd == CMD_TEST) begin
                        base_next = {2'b00, s_data.bit_index[7:3], 3'b000};
                    end else begin
                        base_next = '0;
                    end
                end
            end
            S_OP: begin
                if ((cmd_reg == CMD_FFS || cmd_reg == CMD_ALLOC) && base_reg < eff_size
                    && !ev.hit) begin
                    base_next = base_reg + 10'd8;
                end else if (out_free) begin
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                    out_next     = '{status: ST_OK, bit_value: 1'b0, position: 9'd0};
                    case (cmd_reg)
                        CMD_SET, CMD_CLEAR: begin
                            if (bit_w >= eff_size) begin
                                out_next.status = ST_RANGE;
                            end else begin
                                wr_en   = 1'b1;
                                wr_data = (cmd_reg == CMD_SET) ? (rd_byte | bit_mask)
                                                               : (rd_byte & ~bit_mask);
                            end
                        end
                        CMD_TEST: begin
                            if (bit_w >= CAP) begin
                                out_next.status = ST_RANGE;
                            end else begin
                                out_next.bit_value = rd_byte[bit_reg[2:0]];
                            end
                        end
                        CMD_FFS: begin
                            if (base_reg < eff_size) begin
                                if (ev.in_size) begin
                                    out_next.position = 9'(ev.pos + 10'd1);
                                end else begin
                                    out_next.status = ST_NOSPACE;
                                end
                            end
                        end
                        CMD_ALLOC: begin
                            if (base_reg < eff_size && ev.in_size) begin
                                wr_en             = 1'b1;
                                wr_data           = rd_byte | (8'h01 << ev.pos[2:0]);
                                out_next.position = ev.pos[8:0];
                            end else begin
                                out_next.status = ST_NOSPACE;
                            end
                        end
                        default: begin
                            out_next.status = ST_RANGE;
                        end
                    endcase
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            size_reg    <= SIZE_RESET;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                size_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg  <= cmd_next;
        bit_reg  <= bit_next;
        base_reg <= base_next;
        out_reg  <= out_next;
    end

endmodule
`default_nettype wire

@@ rtl/core/bba_map_mem.sv @@
`default_nettype none
module bba_map_mem #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic [AW-1:0] rd_addr,
    output logic [7:0]         rd_data,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [7:0]    wr_data
);

    logic [7:0] mem_reg [DEPTH];
    logic [DEPTH-1:0] vld_reg;
    logic [7:0] rd_data_reg;

    // entries never written read as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (wr_en) begin
            vld_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (int'(rd_addr) < DEPTH && vld_reg[rd_addr]) begin
            rd_data_reg <= mem_reg[rd_addr];
        end else begin
            rd_data_reg <= 8'h00;
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

@@ rtl/core/bba_byte_eval.sv @@
`default_nettype none
module bba_byte_eval import bba_pkg::*; (
    input  wire logic [7:0]       byte_in,
    input  wire logic             find_zero,
    input  wire logic [POS_W-1:0] base,
    input  wire logic [POS_W-1:0] eff_size,
    output eval_t                 res
);

    logic [7:0] vec;
    logic [2:0] idx;

    always_comb begin
        vec = find_zero ? ~byte_in : byte_in;
        idx = 3'd0;
        for (int k = 7; k >= 0; k--) begin
            if (vec[k]) begin
                idx = 3'(k);
            end
        end
        res.hit     = |vec;
        res.pos     = base + {7'd0, idx};
        res.in_size = res.pos < eff_size;
    end

endmodule
`default_nettype wire

@@ rtl/core/bba_checker.sv @@
`default_nettype none
module bba_checker import bba_pkg::*; (
    input wire logic              aclk,
    input wire logic              aresetn,
    input wire logic              s_valid,
    input wire logic              s_ready,
    input wire logic              m_valid,
    input wire logic              m_ready,
    input wire out_item_t         m_data
);

    // result held until transferred
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // one command in flight at a time
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("ready high right after an input transfer");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.status != 2'd3)
        else $error("undefined status code");

    a_err_no_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status != ST_OK |-> m_data.position == 9'd0 && !m_data.bit_value)
        else $error("error result carries a position or bit value");

endmodule

bind bitmap_bit_allocator_unit bba_checker u_bba_checker (.*);
`default_nettype wire
